[rtl/core/spu8r_pkg.sv]
package spu8r_pkg;

  // The window never holds more than eight pending bytes, so eight entries suffice.
  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(WIN_DEPTH);
  localparam int unsigned HIST_LEN  = 3;

  // Bytes consumed by one decision.
  localparam int unsigned SHIFT_PAIR = 6;
  localparam int unsigned SHIFT_REPL = 3;
  localparam int unsigned SHIFT_PASS = 1;

  // A held high surrogate is three bytes long.
  localparam logic [CNT_W-1:0] HOLD_LEN = CNT_W'(3);

  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [7:0] SURR_LEAD = 8'hED;
  localparam logic [7:0] HI_MIN    = 8'hA0;
  localparam logic [7:0] HI_MAX    = 8'hAF;
  localparam logic [7:0] LO_MIN    = 8'hB0;
  localparam logic [7:0] LO_MAX    = 8'hBF;
  localparam logic [7:0] REPL_B0   = 8'hEF;
  localparam logic [7:0] REPL_B1   = 8'hBF;
  localparam logic [7:0] REPL_B2   = 8'hBD;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_TAIL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DEC_PASS,
    DEC_REPL,
    DEC_PAIR
  } dec_kind_t;

  typedef struct packed {
    logic load;
    logic emit_dec;
    logic emit_tail;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic tail_due;
    logic out_free;
    logic tail_last;
  } dp_status_t;

endpackage

[rtl/core/surrogate_pair_utf8_repair.sv]
// Surrogate pair repair for a UTF-8 byte stream. Each input item carries one data
// byte with a chunk-end mark, or a flush. An encoded surrogate pair (ED A0-AF x,
// ED B0-BF y) leaves as one four-byte UTF-8 sequence, a lone three-byte surrogate
// leaves as EF BF BD, and every other byte passes unchanged; a high surrogate at
// the end of a chunk is kept back for the next chunk, and a flush while one is kept
// back emits EF BF BD. The last byte caused by an input item carries the last flag;
// an item may cause no bytes at all. The block handles one item at a time: it takes
// an item in, then produces its output bytes one at a time (one byte per cycle
// while the output side keeps up, the output register being the only place a
// byte can wait), and then finds that no decision is left before it takes the next
// item. This rate is set by the single output register fed by one decision unit on
// the window head. A chunk end can release up to eight pending bytes. While the
// previous item's last byte waits in the output register the next item is already
// taken in.
module surrogate_pair_utf8_repair (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spu8r_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spu8r_pkg::out_item_t  out_data
);

  // Commands from the controller to the datapath, and status back.
  spu8r_pkg::dp_cmd_t    cmd;
  spu8r_pkg::dp_status_t status;

  // The controller sequences an item: take it in, step through decisions on the
  // window head one output byte at a time, then emit the replacement tail if a
  // flush found a held surrogate.
  spu8r_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the lookahead window, its fill count and decision limit,
  // the decision logic and the output register.
  spu8r_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/spu8r_ctrl.sv]
module spu8r_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  spu8r_pkg::dp_status_t  status,
  output spu8r_pkg::dp_cmd_t     cmd
);

  spu8r_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spu8r_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spu8r_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = spu8r_pkg::ST_WORK;
        end
      end
      spu8r_pkg::ST_WORK: begin
        if (!status.more) begin
          state_nxt = status.tail_due ? spu8r_pkg::ST_TAIL : spu8r_pkg::ST_IDLE;
        end
      end
      spu8r_pkg::ST_TAIL: begin
        if (status.out_free && status.tail_last) begin
          state_nxt = spu8r_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spu8r_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      spu8r_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      spu8r_pkg::ST_WORK: begin
        cmd.emit_dec = status.more && status.out_free;
      end
      spu8r_pkg::ST_TAIL: begin
        cmd.emit_tail = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/spu8r_dp.sv]
module spu8r_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spu8r_pkg::in_item_t    in_data,
  input  spu8r_pkg::dp_cmd_t     cmd,
  output spu8r_pkg::dp_status_t  status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output spu8r_pkg::out_item_t   out_data
);

  function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  logic [7:0]                  win_r  [spu8r_pkg::WIN_DEPTH];
  logic [7:0]                  hist_r [spu8r_pkg::HIST_LEN];
  logic [spu8r_pkg::CNT_W-1:0] cnt_r;
  logic [spu8r_pkg::CNT_W-1:0] lim_r;
  logic                        drain_r;
  logic                        flush_r;
  logic                        hold_r;
  logic [1:0]                  j_r;
  logic                        out_valid_r;
  spu8r_pkg::out_item_t        out_r;

  spu8r_pkg::dec_kind_t        kind;
  logic                        is_pair;
  logic                        is_repl;
  logic [9:0]                  hi_off;
  logic [9:0]                  lo_off;
  logic [20:0]                 cp;
  logic [7:0]                  dec_byte;
  logic [7:0]                  tail_byte;
  logic [1:0]                  last_idx;
  logic [spu8r_pkg::CNT_W-1:0] consume;
  logic                        dec_last;
  logic                        more;
  logic                        more_after;
  logic                        tail_due;
  logic                        dec_out_last;
  logic                        tail_last;
  logic                        out_free;
  logic [spu8r_pkg::CNT_W-1:0] n_data;
  logic                        data_hold;
  logic                        flush_hold;

  // Decision on the head of the window, limited to lim_r usable bytes.
  assign is_pair = (lim_r >= spu8r_pkg::CNT_W'(spu8r_pkg::SHIFT_PAIR)) &&
                   (win_r[0] == spu8r_pkg::SURR_LEAD) &&
                   in_rng(win_r[1], spu8r_pkg::HI_MIN, spu8r_pkg::HI_MAX) &&
                   (win_r[3] == spu8r_pkg::SURR_LEAD) &&
                   in_rng(win_r[4], spu8r_pkg::LO_MIN, spu8r_pkg::LO_MAX);
  assign is_repl = (lim_r >= spu8r_pkg::CNT_W'(spu8r_pkg::SHIFT_REPL)) &&
                   (win_r[0] == spu8r_pkg::SURR_LEAD) &&
                   in_rng(win_r[1], spu8r_pkg::HI_MIN, spu8r_pkg::LO_MAX);

  always_comb begin
    if (is_pair) begin
      kind = spu8r_pkg::DEC_PAIR;
    end else if (is_repl) begin
      kind = spu8r_pkg::DEC_REPL;
    end else begin
      kind = spu8r_pkg::DEC_PASS;
    end
  end

  // The second byte of a high surrogate lies in A0..AF, so its low nibble with the
  // third byte gives the offset from D800; likewise for the low surrogate from DC00.
  assign hi_off = {win_r[1][3:0], win_r[2][5:0]};
  assign lo_off = {win_r[4][3:0], win_r[5][5:0]};
  assign cp     = spu8r_pkg::SUPP_BASE + {1'b0, hi_off, lo_off};

  always_comb begin
    dec_byte = win_r[0];
    last_idx = 2'd0;
    consume  = spu8r_pkg::CNT_W'(spu8r_pkg::SHIFT_PASS);
    case (kind)
      spu8r_pkg::DEC_PAIR: begin
        last_idx = 2'd3;
        consume  = spu8r_pkg::CNT_W'(spu8r_pkg::SHIFT_PAIR);
        case (j_r)
          2'd0:    dec_byte = spu8r_pkg::LEAD4 | {5'd0, cp[20:18]};
          2'd1:    dec_byte = spu8r_pkg::CONT_TAG | {2'd0, cp[17:12]};
          2'd2:    dec_byte = spu8r_pkg::CONT_TAG | {2'd0, cp[11:6]};
          default: dec_byte = spu8r_pkg::CONT_TAG | {2'd0, cp[5:0]};
        endcase
      end
      spu8r_pkg::DEC_REPL: begin
        last_idx = 2'd2;
        consume  = spu8r_pkg::CNT_W'(spu8r_pkg::SHIFT_REPL);
        case (j_r)
          2'd0:    dec_byte = spu8r_pkg::REPL_B0;
          2'd1:    dec_byte = spu8r_pkg::REPL_B1;
          default: dec_byte = spu8r_pkg::REPL_B2;
        endcase
      end
      default: begin
        dec_byte = win_r[0];
      end
    endcase
  end

  always_comb begin
    case (j_r)
      2'd0:    tail_byte = spu8r_pkg::REPL_B0;
      2'd1:    tail_byte = spu8r_pkg::REPL_B1;
      default: tail_byte = spu8r_pkg::REPL_B2;
    endcase
  end

  assign dec_last   = (j_r == last_idx);
  assign more       = drain_r ? (lim_r != '0)
                              : (cnt_r >= spu8r_pkg::CNT_W'(spu8r_pkg::WIN_DEPTH));
  assign more_after = drain_r ? (lim_r != consume)
                              : ((cnt_r - consume) >=
                                 spu8r_pkg::CNT_W'(spu8r_pkg::WIN_DEPTH));
  assign tail_due     = flush_r && hold_r;
  assign dec_out_last = dec_last && !more_after && !tail_due;
  assign tail_last    = (j_r == 2'd2);
  assign out_free     = !out_valid_r || !out_stall;

  // The window always holds the most recently appended bytes, so the tail of
  // the window can be read from the short history of appended bytes.
  assign n_data     = cnt_r + spu8r_pkg::CNT_W'(1);
  assign data_hold  = in_data.chunk_end && (n_data >= spu8r_pkg::HOLD_LEN) &&
                      (hist_r[1] == spu8r_pkg::SURR_LEAD) &&
                      in_rng(hist_r[0], spu8r_pkg::HI_MIN, spu8r_pkg::HI_MAX);
  assign flush_hold = (cnt_r >= spu8r_pkg::HOLD_LEN) &&
                      (hist_r[2] == spu8r_pkg::SURR_LEAD) &&
                      in_rng(hist_r[1], spu8r_pkg::HI_MIN, spu8r_pkg::HI_MAX);

  // Window bytes and history: payload, no reset.
  always_ff @(posedge clk) begin
    if (cmd.load && (in_data.func == spu8r_pkg::FUNC_DATA)) begin
      if (cnt_r < spu8r_pkg::CNT_W'(spu8r_pkg::WIN_DEPTH)) begin
        win_r[cnt_r[spu8r_pkg::IDX_W-1:0]] <= in_data.data_byte;
      end
      hist_r[0] <= in_data.data_byte;
      for (int i = 1; i < spu8r_pkg::HIST_LEN; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end else if (cmd.emit_dec && dec_last) begin
      case (kind)
        spu8r_pkg::DEC_PAIR: begin
          for (int i = 0; i < spu8r_pkg::WIN_DEPTH - spu8r_pkg::SHIFT_PAIR; i++) begin
            win_r[i] <= win_r[i + spu8r_pkg::SHIFT_PAIR];
          end
        end
        spu8r_pkg::DEC_REPL: begin
          for (int i = 0; i < spu8r_pkg::WIN_DEPTH - spu8r_pkg::SHIFT_REPL; i++) begin
            win_r[i] <= win_r[i + spu8r_pkg::SHIFT_REPL];
          end
        end
        default: begin
          for (int i = 0; i < spu8r_pkg::WIN_DEPTH - spu8r_pkg::SHIFT_PASS; i++) begin
            win_r[i] <= win_r[i + spu8r_pkg::SHIFT_PASS];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lim_r       <= '0;
      drain_r     <= 1'b0;
      flush_r     <= 1'b0;
      hold_r      <= 1'b0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        j_r <= '0;
        if (in_data.func == spu8r_pkg::FUNC_FLUSH) begin
          drain_r <= 1'b1;
          flush_r <= 1'b1;
          hold_r  <= flush_hold;
          lim_r   <= flush_hold ? (cnt_r - spu8r_pkg::HOLD_LEN) : cnt_r;
        end else begin
          cnt_r   <= n_data;
          drain_r <= in_data.chunk_end;
          flush_r <= 1'b0;
          hold_r  <= data_hold;
          lim_r   <= data_hold ? (n_data - spu8r_pkg::HOLD_LEN) : n_data;
        end
      end else if (cmd.emit_dec) begin
        if (dec_last) begin
          j_r   <= '0;
          cnt_r <= cnt_r - consume;
          lim_r <= lim_r - consume;
        end else begin
          j_r <= j_r + 2'd1;
        end
      end else if (cmd.emit_tail) begin
        if (tail_last) begin
          j_r   <= '0;
          cnt_r <= '0;
        end else begin
          j_r <= j_r + 2'd1;
        end
      end

      if (cmd.emit_dec || cmd.emit_tail) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_dec) begin
      out_r <= '{out_byte: dec_byte, last: dec_out_last};
    end else if (cmd.emit_tail) begin
      out_r <= '{out_byte: tail_byte, last: tail_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign status.more      = more;
  assign status.tail_due  = tail_due;
  assign status.out_free  = out_free;
  assign status.tail_last = tail_last;

  a_lim_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r <= cnt_r)
    else $error("decision limit runs past the window fill");

  a_emit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_dec || cmd.emit_tail) |-> out_free)
    else $error("byte emitted while the output register is still occupied");

  a_tail_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_tail |-> (hold_r && (cnt_r == spu8r_pkg::HOLD_LEN)))
    else $error("replacement tail without a held surrogate in the window");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && (in_data.func == spu8r_pkg::FUNC_DATA)) |=>
      (cnt_r == $past(cnt_r) + spu8r_pkg::CNT_W'(1)))
    else $error("appended byte did not grow the window");

endmodule
